[design/srom_pkg.sv]
`default_nettype none
package srom_pkg;

  // Geometry of the serial transfer
  localparam int unsigned ADDR_BITS = 6;
  localparam int unsigned OPC_LEN   = 3;
  localparam int unsigned DATA_LEN  = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned MAC_W     = 48;

  // Bit counter marks: end of opcode, end of address, end of the whole sequence
  localparam logic [CNT_W-1:0] OPC_END  = CNT_W'(OPC_LEN);
  localparam logic [CNT_W-1:0] ADDR_END = CNT_W'(OPC_LEN + ADDR_BITS);
  localparam logic [CNT_W-1:0] SEQ_END  = CNT_W'(OPC_LEN + ADDR_BITS + DATA_LEN);

  // ROM layout
  localparam logic [OPC_LEN-1:0]   READ_OPCODE        = 3'd6;
  localparam logic [ADDR_BITS-1:0] VERSION_WORD_INDEX = 6'd9;
  localparam logic [ADDR_BITS-1:0] MAC_WORD0_INDEX    = 6'd10;
  localparam logic [ADDR_BITS-1:0] MAC_WORD1_INDEX    = 6'd11;
  localparam logic [ADDR_BITS-1:0] MAC_WORD2_INDEX    = 6'd12;
  localparam logic [DATA_LEN-1:0]  VERSION_WORD       = 16'h0101;

  // One write of the pin register
  typedef struct packed {
    logic chip_select;
    logic serial_clock;
    logic serial_in;
  } pin_t;

  // ROM contents; the station address words win over the version word
  function automatic logic [DATA_LEN-1:0] rom_word(input logic [ADDR_BITS-1:0] addr,
                                                   input logic [MAC_W-1:0]     mac);
    logic [DATA_LEN-1:0] word;
    word = '0;
    if (addr == MAC_WORD0_INDEX) begin
      word = mac[15:0];
    end else if (addr == MAC_WORD1_INDEX) begin
      word = mac[31:16];
    end else if (addr == MAC_WORD2_INDEX) begin
      word = mac[47:32];
    end else if (addr == VERSION_WORD_INDEX) begin
      word = VERSION_WORD;
    end
    return word;
  endfunction

endpackage
`default_nettype wire

[design/srom_if.sv]
`default_nettype none
// Pin register writes toward the ROM
interface srom_pin_if;
  logic valid;
  logic ready;
  logic chip_select;
  logic serial_clock;
  logic serial_in;

  modport source (output valid, output chip_select, output serial_clock, output serial_in,
                  input ready);
  modport sink   (input valid, input chip_select, input serial_clock, input serial_in,
                  output ready);
endinterface

// Data-out bit seen after each write
interface srom_out_if;
  logic valid;
  logic ready;
  logic serial_out;

  modport source (output valid, output serial_out, input ready);
  modport sink   (input valid, input serial_out, output ready);
endinterface
`default_nettype wire

[design/srom_step.sv]
`default_nettype none
module srom_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire srom_pkg::pin_t               pin_i,
  input  wire logic [srom_pkg::MAC_W-1:0]   mac_i,
  output logic                              serial_out_o
);

  logic                                prev_sel_q, prev_sel_d;
  logic [srom_pkg::CNT_W-1:0]          cnt_q, cnt_d, cnt0, cnt_inc;
  logic [srom_pkg::OPC_LEN-1:0]        opc_q, opc_d, opc0;
  logic                                started_q, started_d, started0;
  logic [srom_pkg::ADDR_BITS-1:0]      addr_q, addr_d, addr0;
  logic                                out_q, out_d;
  logic                                restart;
  logic                                move;
  logic [srom_pkg::CNT_W-1:0]          pos_full;
  logic [3:0]                          pos;
  logic [srom_pkg::DATA_LEN-1:0]       word;
  logic [srom_pkg::DATA_LEN-1:0]       word_sh;

  // Rising select clears the sequence before the bit is handled
  assign restart  = pin_i.chip_select && !prev_sel_q;
  assign cnt0     = restart ? '0 : cnt_q;
  assign opc0     = restart ? '0 : opc_q;
  assign started0 = restart ? 1'b0 : started_q;
  assign addr0    = restart ? '0 : addr_q;

  // Skip leading zeros before the opcode
  assign move     = pin_i.serial_clock && (pin_i.serial_in || started0);
  assign cnt_inc  = cnt0 + 1'b1;

  // Data phase: pick the bit of the addressed word, MSB first
  assign pos_full = cnt0 - srom_pkg::ADDR_END;
  assign pos      = pos_full[3:0];
  assign word     = srom_pkg::rom_word(addr_q, mac_i);
  assign word_sh  = word << pos;

  // Next state of one bit
  always_comb begin
    prev_sel_d = pin_i.chip_select;
    cnt_d      = cnt0;
    opc_d      = opc0;
    started_d  = started0;
    addr_d     = addr0;
    out_d      = out_q;
    if (move) begin
      if (cnt0 < srom_pkg::OPC_END) begin
        started_d = 1'b1;
        opc_d     = {opc0[srom_pkg::OPC_LEN-2:0], pin_i.serial_in};
      end else begin
        out_d = 1'b0;
        if (opc0 == srom_pkg::READ_OPCODE) begin
          if (cnt0 < srom_pkg::ADDR_END) begin
            out_d  = (cnt0 != srom_pkg::ADDR_END - 1'b1);
            addr_d = {addr0[srom_pkg::ADDR_BITS-2:0], pin_i.serial_in};
          end else begin
            out_d = word_sh[srom_pkg::DATA_LEN-1];
          end
        end
      end
      cnt_d = cnt_inc;
      // End of the sequence: start over, keep data-out
      if (cnt_inc >= srom_pkg::SEQ_END) begin
        cnt_d     = '0;
        opc_d     = '0;
        started_d = 1'b0;
        addr_d    = '0;
      end
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sel_q <= 1'b0;
      cnt_q      <= '0;
      opc_q      <= '0;
      started_q  <= 1'b0;
      addr_q     <= '0;
      out_q      <= 1'b0;
    end else if (fire_i) begin
      prev_sel_q <= prev_sel_d;
      cnt_q      <= cnt_d;
      opc_q      <= opc_d;
      started_q  <= started_d;
      addr_q     <= addr_d;
      out_q      <= out_d;
    end
  end

  assign serial_out_o = out_d;

endmodule
`default_nettype wire

[design/serial_eeprom_read_responder_core.sv]
// Serial ROM read responder.
// pin_i takes one write of the ROM pin register per transfer (chip_select,
// serial_clock, serial_in); dout_o returns exactly one serial_out bit per
// write, in order: the data-out level the ROM drives after that write.
// cfg_we_i/cfg_wdata_i load the 48-bit station address; write it only while
// no write is in flight.
// A write accepted into the input register passes on to the result register
// when the result stage frees up.
// Throughput: one write per cycle while dout_o.ready is high; the single-bit
// step between the input register and the result register sets that figure.
// Stall: when the receiver holds dout_o.ready low, the result register keeps
// its bit and one more write waits in the input register; pin_i.ready drops
// only while both are full and the result is not taken.
// Reset clears the sequencer state, the data-out bit and the station address
// to zero and empties both registers; there is no clearing pass.
`default_nettype none
module serial_eeprom_read_responder_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  srom_pin_if.sink                         pin_i,
  srom_out_if.source                       dout_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [srom_pkg::MAC_W-1:0]  cfg_wdata_i
);

  logic                        in_vld_q;
  srom_pkg::pin_t              in_q;
  logic                        res_vld_q;
  logic                        res_q;
  logic                        res_free;
  logic                        advance;
  logic                        step_out;
  logic [srom_pkg::MAC_W-1:0]  mac_q;

  // Station address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '0;
    end else if (cfg_we_i) begin
      mac_q <= cfg_wdata_i;
    end
  end

  // Handshake: move the input stage forward when the result stage frees up
  assign res_free    = !res_vld_q || dout_o.ready;
  assign advance     = in_vld_q && res_free;
  assign pin_i.ready = !in_vld_q || res_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pin_i.ready) begin
      in_vld_q <= pin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pin_i.ready && pin_i.valid) begin
      in_q <= '{chip_select:  pin_i.chip_select,
                serial_clock: pin_i.serial_clock,
                serial_in:    pin_i.serial_in};
    end
  end

  // Sequencer for one bit
  srom_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .pin_i        (in_q),
    .mac_i        (mac_q),
    .serial_out_o (step_out)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_out;
    end
  end

  assign dout_o.valid      = res_vld_q;
  assign dout_o.serial_out = res_q;

endmodule
`default_nettype wire

[design/srom_checker.sv]
`default_nettype none
module srom_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic serial_out_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(serial_out_i))
    else $error("stalled result changed or dropped");

  // Input back-pressure only while a result waits untaken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // An accepted transfer reaches the output when the receiver is ready while it sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after accepted write");

  // No result appears without a write before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2) || $past(!in_ready_i, 2)
                           || $past(out_valid_i && out_ready_i))
    else $error("result without write");

endmodule

bind serial_eeprom_read_responder_core srom_checker u_srom_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pin_i.valid),
  .in_ready_i   (pin_i.ready),
  .out_valid_i  (dout_o.valid),
  .out_ready_i  (dout_o.ready),
  .serial_out_i (dout_o.serial_out)
);
`default_nettype wire
